/* hw/rtl/f16pd_pkg.sv */
package f16pd_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] CNT_MAX       = 16'hFFFF;
  localparam logic [8:0]  FLETCHER_MOD  = 9'd255;

  localparam logic [2:0] HDR_LEN = 3'd3;

  localparam logic [7:0] CODE_HEARTBEAT = 8'h01;
  localparam logic [7:0] CODE_FORWARD   = 8'h02;
  localparam logic [7:0] CODE_ROTATE    = 8'h04;
  localparam logic [7:0] CODE_ACK       = 8'h08;
  localparam logic [7:0] CODE_LIFT      = 8'h10;
  localparam logic [7:0] CODE_SCORE     = 8'h20;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [2:0] {
    ST_ACTION    = 3'd0,
    ST_HEARTBEAT = 3'd1,
    ST_ACK       = 3'd2,
    ST_BADSUM    = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  command_code;
    logic [7:0]  sequence_res;
    logic [7:0]  argument;
    logic        link_online;
    logic [15:0] dropped_count;
  } res_t;

  function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= FLETCHER_MOD) begin
      s = s - FLETCHER_MOD;
    end
    return s[7:0];
  endfunction

  function automatic status_t classify(input logic [7:0] code);
    status_t st;
    case (code)
      CODE_HEARTBEAT: st = ST_HEARTBEAT;
      CODE_FORWARD,
      CODE_ROTATE,
      CODE_LIFT,
      CODE_SCORE:     st = ST_ACTION;
      CODE_ACK:       st = ST_ACK;
      default:        st = ST_UNKNOWN;
    endcase
    return st;
  endfunction

endpackage

/* hw/rtl/f16pd_cfg.sv */
module f16pd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [f16pd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [f16pd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [f16pd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output logic [15:0]                   timeout_ticks
);

  logic [15:0] timeout_r;
  logic [15:0] timeout_nxt;
  logic        sel_timeout;

  assign sel_timeout = (cfg_paddr[2] == f16pd_pkg::REG_TIMEOUT);

  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_timeout) begin
      timeout_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= f16pd_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  assign cfg_pready    = 1'b1;
  assign cfg_prdata    = sel_timeout ? {16'd0, timeout_r} : '0;
  assign timeout_ticks = timeout_r;

endmodule

/* hw/rtl/f16pd_core.sv */
module f16pd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               command,
  input  logic [7:0]         rx_byte,
  input  logic [15:0]        timeout_ticks,
  output logic               res_valid,
  output f16pd_pkg::res_t    res
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  hdr_r [3];
  logic        hdr_we;
  logic [7:0]  chk_hi_r, chk_hi_nxt;
  logic [7:0]  sum_lo_r, sum_lo_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [15:0] drop_r, drop_nxt;
  logic        online_r, online_nxt;
  logic [15:0] age_r, age_nxt;
  f16pd_pkg::status_t st;

  always_comb begin
    pos_nxt    = pos_r;
    hdr_we     = 1'b0;
    chk_hi_nxt = chk_hi_r;
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    drop_nxt   = drop_r;
    online_nxt = online_r;
    age_nxt    = age_r;
    st         = f16pd_pkg::ST_BADSUM;
    res_valid  = 1'b0;
    if (fire) begin
      if (command == f16pd_pkg::CMD_TICK) begin
        if (age_r != f16pd_pkg::CNT_MAX) begin
          age_nxt = age_r + 16'd1;
        end
        if (age_nxt > timeout_ticks) begin
          online_nxt = 1'b0;
        end
      end else if (pos_r < f16pd_pkg::HDR_LEN) begin
        hdr_we     = 1'b1;
        sum_lo_nxt = f16pd_pkg::mod_add(sum_lo_r, rx_byte);
        sum_hi_nxt = f16pd_pkg::mod_add(sum_hi_r, sum_lo_nxt);
        pos_nxt    = pos_r + 3'd1;
      end else if (pos_r == f16pd_pkg::HDR_LEN) begin
        chk_hi_nxt = rx_byte;
        pos_nxt    = pos_r + 3'd1;
      end else begin
        res_valid = 1'b1;
        if ((chk_hi_r == sum_hi_r) && (rx_byte == sum_lo_r)) begin
          online_nxt = 1'b1;
          st         = f16pd_pkg::classify(hdr_r[0]);
          if (st == f16pd_pkg::ST_HEARTBEAT) begin
            age_nxt = '0;
          end
        end else if (drop_r != f16pd_pkg::CNT_MAX) begin
          drop_nxt = drop_r + 16'd1;
        end
        pos_nxt    = '0;
        sum_lo_nxt = '0;
        sum_hi_nxt = '0;
      end
    end
  end

  always_comb begin
    res.status        = st;
    res.command_code  = hdr_r[0];
    res.sequence_res  = hdr_r[1];
    res.argument      = hdr_r[2];
    res.link_online   = online_nxt;
    res.dropped_count = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_lo_r <= '0;
      sum_hi_r <= '0;
      drop_r   <= '0;
      online_r <= 1'b0;
      age_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
      drop_r   <= drop_nxt;
      online_r <= online_nxt;
      age_r    <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_hi_r <= chk_hi_nxt;
    if (hdr_we) begin
      hdr_r[pos_r[1:0]] <= rx_byte;
    end
  end

endmodule

/* hw/rtl/f16pd_outbuf.sv */
module f16pd_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  f16pd_pkg::res_t  push_res,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output f16pd_pkg::res_t  out_res
);

  logic            head_valid_r, head_valid_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  f16pd_pkg::res_t head_r, head_nxt;
  f16pd_pkg::res_t skid_r, skid_nxt;
  logic            pop;

  assign pop = head_valid_r && out_ready;

  always_comb begin
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!head_valid_r || pop) begin
      if (skid_valid_r) begin
        head_nxt       = skid_r;
        head_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        head_nxt       = push_res;
        head_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ready  = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_res   = head_r;

endmodule

/* hw/rtl/fletcher16_packet_deframer.sv */
// Fletcher-16 packet deframer. Each transaction is a received byte (in_command
// 0) or a millisecond tick (in_command 1). Five bytes form a packet (command,
// sequence, argument, checksum high, checksum low); the fifth byte produces one
// result on the out_ channel; ticks and other bytes produce none. The state
// update is a single registered pass, so sustained rate is one transaction per
// cycle while in_ready is high; a two-entry output buffer lets input continue
// while one result waits, and in_ready drops only when both entries are full.
// Register timeout_ticks (byte address 0, reset 100) sets the heartbeat age
// beyond which the link reads offline; write it only while the block is idle.
module fletcher16_packet_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [7:0]                    out_command_code,
  output logic [7:0]                    out_sequence_res,
  output logic [7:0]                    out_argument,
  output logic                          out_link_online,
  output logic [15:0]                   out_dropped_count,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [f16pd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [f16pd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [f16pd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  logic            fire;
  logic [15:0]     timeout_ticks;
  logic            res_valid;
  f16pd_pkg::res_t res;
  f16pd_pkg::res_t out_res;

  assign fire = in_valid && in_ready;

  f16pd_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .timeout_ticks (timeout_ticks)
  );

  f16pd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .command       (in_command),
    .rx_byte       (in_rx_byte),
    .timeout_ticks (timeout_ticks),
    .res_valid     (res_valid),
    .res           (res)
  );

  f16pd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_command_code  = out_res.command_code;
  assign out_sequence_res  = out_res.sequence_res;
  assign out_argument      = out_res.argument;
  assign out_link_online   = out_res.link_online;
  assign out_dropped_count = out_res.dropped_count;

  a_res_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (fire && (in_command == f16pd_pkg::CMD_BYTE)))
    else $error("result without an accepted byte");

  a_good_sets_online: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status != f16pd_pkg::ST_BADSUM)) |-> res.link_online)
    else $error("valid packet did not mark link online");

  a_bad_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == f16pd_pkg::ST_BADSUM)) |-> (res.dropped_count != 16'd0))
    else $error("bad checksum not counted");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid)
    else $error("result lost in output buffer");

endmodule
